### design/oesa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oesa_pkg: shared constants for the oldest-evict slot allocator
// Field widths, result status codes and reset/default values.
// ----------------------------------------------------------------------------
package oesa_pkg;

  localparam int DEFAULT_NUM_SLOTS = 20;

  localparam int IDX_W    = 8;   // slot_index field
  localparam int COMP_W   = 16;  // compression count and threshold
  localparam int SEQ_W    = 8;   // insertion sequence
  localparam int STATUS_W = 3;
  localparam int SLOT_OUT_W  = 5;
  localparam int COUNT_OUT_W = 5;

  localparam logic [COMP_W-1:0] MIN_COMP_RESET = 16'd1;
  localparam logic [SEQ_W-1:0]  SEQ_RESET      = 8'd1;

  // kind field
  localparam logic KIND_SAVE    = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_SAVED       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_FEW     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_WRITE_FAIL  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RELEASED    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 3'd4;

endpackage
`default_nettype wire

### design/oldest_evict_slot_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oldest_evict_slot_allocator: pending-session slot table
// Save requests take the lowest empty slot, or evict the oldest pending slot
// by wrapped sequence age; release requests clear a slot.
// ----------------------------------------------------------------------------
//
// Channel   Signals                                         Handshake
// --------  ----------------------------------------------  -----------------
// request   kind, slot_index, compression_count, write_ok   start & !busy
// result    status, chosen_slot, evicted, pending_count     done (one cycle)
// config    cfg_wr_data (min_compressions)                  cfg_wr_en
//
// Release and below-threshold saves are decided at the accept edge, where
//   done is registered; busy never rises for them.
// Other saves walk the pending bits one slot a cycle looking for a gap; with
//   every slot full a second walk reads the sequence RAM one slot a cycle
//   (one port, registered read), then the result is committed in S_COMMIT.
// Reset clears pending bits, the pending count and sets the sequence counter
//   to 1; the sequence RAM needs no clearing as it is only read when all
//   slots are pending, hence all written.
// The receiver cannot stall: each word sits on the result ports for the one
//   cycle that done is high.
// ----------------------------------------------------------------------------
module oldest_evict_slot_allocator #(
  parameter int NUM_SLOTS = oesa_pkg::DEFAULT_NUM_SLOTS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // request
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              kind,
  input  wire logic [oesa_pkg::IDX_W-1:0]        slot_index,
  input  wire logic [oesa_pkg::COMP_W-1:0]       compression_count,
  input  wire logic                              write_ok,
  // configuration
  input  wire logic                              cfg_wr_en,
  input  wire logic [oesa_pkg::COMP_W-1:0]       cfg_wr_data,
  // result
  output logic                                   done,
  output logic [oesa_pkg::STATUS_W-1:0]          status,
  output logic [oesa_pkg::SLOT_OUT_W-1:0]        chosen_slot,
  output logic                                   evicted,
  output logic [oesa_pkg::COUNT_OUT_W-1:0]       pending_count
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam logic [SLOT_W-1:0]           LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);
  localparam logic [oesa_pkg::IDX_W-1:0]  NUM_SLOTS_B = oesa_pkg::IDX_W'(NUM_SLOTS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FREE,    // look for the lowest empty slot
    S_AGE,     // all full: find the oldest by wrapped age
    S_COMMIT
  } state_t;

  state_t state;

  // slot table: pending bits in flops, sequences in a RAM
  logic [NUM_SLOTS-1:0]            pending;
  logic [oesa_pkg::SEQ_W-1:0]      seq_mem [NUM_SLOTS];
  logic [oesa_pkg::SEQ_W-1:0]      seq_rd;

  logic [oesa_pkg::SEQ_W-1:0]      next_seq;
  logic [CNT_W-1:0]                count;
  logic [oesa_pkg::COMP_W-1:0]     min_comp;

  // sequencer working registers
  logic [SLOT_W-1:0]               scan_idx;    // RAM / pending address
  logic                            issue_done;  // last RAM read issued
  logic [SLOT_W-1:0]               rd_idx;      // slot whose data is in seq_rd
  logic                            rd_valid;
  logic [oesa_pkg::SEQ_W-1:0]      best_age;
  logic [SLOT_W-1:0]               chosen;
  logic                            full;
  logic                            lat_write_ok;

  logic                            accept;
  logic                            in_range;
  logic [SLOT_W-1:0]               rel_idx;
  logic [oesa_pkg::SEQ_W-1:0]      age;
  logic [oesa_pkg::SEQ_W-1:0]      seq_inc;
  logic [oesa_pkg::SEQ_W-1:0]      seq_next;
  logic                            mem_we;
  logic [oesa_pkg::IDX_W-1:0]      slot_ext;
  logic [oesa_pkg::IDX_W-1:0]      count_ext;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign in_range = (slot_index < NUM_SLOTS_B);
  assign rel_idx  = slot_index[SLOT_W-1:0];
  assign age      = next_seq - seq_rd;
  assign seq_inc  = next_seq + oesa_pkg::SEQ_W'(1);
  // counter skips zero on wrap
  assign seq_next = (seq_inc == '0) ? oesa_pkg::SEQ_RESET : seq_inc;
  assign mem_we   = (state == S_COMMIT) && lat_write_ok;

  // Sequence RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      seq_mem[chosen] <= next_seq;
    end
    seq_rd <= seq_mem[scan_idx];
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_comp <= oesa_pkg::MIN_COMP_RESET;
    end else if (cfg_wr_en) begin
      min_comp <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pending    <= '0;
      next_seq   <= oesa_pkg::SEQ_RESET;
      count      <= '0;
      done       <= 1'b0;
      scan_idx   <= '0;
      issue_done <= 1'b0;
      rd_valid   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            lat_write_ok <= write_ok;
            evicted      <= 1'b0;
            if (kind == oesa_pkg::KIND_RELEASE) begin
              done <= 1'b1;
              if (in_range) begin
                pending[rel_idx] <= 1'b0;
                if (pending[rel_idx]) begin
                  count <= count - CNT_W'(1);
                end
                chosen <= rel_idx;
                status <= oesa_pkg::ST_RELEASED;
              end else begin
                chosen <= '0;
                status <= oesa_pkg::ST_OUT_OF_RANGE;
              end
            end else if (compression_count < min_comp) begin
              done   <= 1'b1;
              chosen <= '0;
              status <= oesa_pkg::ST_TOO_FEW;
            end else begin
              done     <= 1'b0;
              scan_idx <= '0;
              state    <= S_FREE;
            end
          end else begin
            done <= 1'b0;
          end
        end

        S_FREE: begin
          done <= 1'b0;
          if (!pending[scan_idx]) begin
            chosen <= scan_idx;
            full   <= 1'b0;
            state  <= S_COMMIT;
          end else if (scan_idx == LAST_SLOT) begin
            full       <= 1'b1;
            scan_idx   <= '0;
            issue_done <= 1'b0;
            rd_valid   <= 1'b0;
            best_age   <= '0;
            state      <= S_AGE;
          end else begin
            scan_idx <= scan_idx + SLOT_W'(1);
          end
        end

        S_AGE: begin
          done <= 1'b0;
          // read for scan_idx issued this cycle, compare the one before it
          rd_idx   <= scan_idx;
          rd_valid <= !issue_done;
          if (!issue_done) begin
            if (scan_idx == LAST_SLOT) begin
              issue_done <= 1'b1;
            end else begin
              scan_idx <= scan_idx + SLOT_W'(1);
            end
          end
          if (rd_valid) begin
            // ties go to the higher slot
            if (age >= best_age) begin
              best_age <= age;
              chosen   <= rd_idx;
            end
            if (rd_idx == LAST_SLOT) begin
              state <= S_COMMIT;
            end
          end
        end

        S_COMMIT: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (lat_write_ok) begin
            pending[chosen] <= 1'b1;
            next_seq        <= seq_next;
            if (!full) begin
              count <= count + CNT_W'(1);
            end
            status  <= oesa_pkg::ST_SAVED;
            evicted <= full;
          end else begin
            status  <= oesa_pkg::ST_WRITE_FAIL;
            evicted <= 1'b0;
          end
        end

        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result fields masked to port width
  assign slot_ext      = oesa_pkg::IDX_W'(chosen);
  assign count_ext     = oesa_pkg::IDX_W'(count);
  assign chosen_slot   = slot_ext[oesa_pkg::SLOT_OUT_W-1:0];
  assign pending_count = count_ext[oesa_pkg::COUNT_OUT_W-1:0];

endmodule
`default_nettype wire
